// ===== rtl/core/bbf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbf_pkg
// Types and constants shared by the blocked bloom filter modules.
// ----------------------------------------------------------------------------
package bbf_pkg;

	// filter geometry
	localparam int WORDS_DEFAULT = 4096;
	localparam int WORD_W        = 64;

	// block count register
	localparam int         BLK_W     = 13;
	localparam logic [12:0] BLK_RESET = 13'd4096;

	// bit position fields of the low hash half
	localparam int POS_W       = 6;
	localparam int POS_SHIFT_A = 24;
	localparam int POS_SHIFT_B = 18;
	localparam int POS_SHIFT_C = 12;
	localparam int POS_SHIFT_D = 6;
	localparam int POS_SHIFT_E = 0;

	// insert counter
	localparam int          CNT_W     = 32;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// remainder unit: quotient bits retired per cycle
	localparam int HIGH_W    = 64;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = HIGH_W / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);
	localparam int REM_W     = BLK_W + 1;

	// input beat
	typedef struct packed {
		logic        kind;
		logic [29:0] hash_low;
		logic [63:0] hash_high;
	} item_t;

	// result beat
	typedef struct packed {
		logic        was_present;
		logic [31:0] insert_total;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic div_step;
		logic check;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic div_last;
	} status_t;

endpackage

// ===== rtl/core/bbf_ram.sv =====
// ----------------------------------------------------------------------------
// bbf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer for the filter: clearing pass, remainder, read, check and update.
// ----------------------------------------------------------------------------
module bbf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bbf_pkg::status_t status,
	output bbf_pkg::cmd_t    cmd,
	output logic             busy
);

	import bbf_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_READ  = 5'b01000,
		S_CHECK = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (status.clear_last) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_DIV;
			S_DIV:   if (status.div_last) state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath commands
	always_comb begin
		cmd.clear    = (state_q == S_CLEAR);
		cmd.load     = (state_q == S_IDLE) && start;
		cmd.div_step = (state_q == S_DIV);
		cmd.check    = (state_q == S_CHECK);
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/bbf_dp.sv =====
// ----------------------------------------------------------------------------
// bbf_dp
// Datapath: block count, remainder unit, mask, filter word store and counter.
// ----------------------------------------------------------------------------
module bbf_dp #(
	parameter int WORDS = bbf_pkg::WORDS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bbf_pkg::cmd_t             cmd,
	output bbf_pkg::status_t          status,
	input  bbf_pkg::item_t            item,
	input  logic                      cfg_we,
	input  logic [bbf_pkg::BLK_W-1:0] cfg_data,
	output logic                      done,
	output bbf_pkg::result_t          result
);

	import bbf_pkg::*;

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [BLK_W-1:0]  blk_q;
	logic [BLK_W-1:0]  n_eff;
	logic [AW-1:0]     clr_ctr_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [HIGH_W-1:0] quot_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_d;
	logic              kind_q;
	logic [WORD_W-1:0] mask_q;
	logic [WORD_W-1:0] mask_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              present;
	logic              do_write;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     blk_addr;
	logic [WORD_W-1:0] ram_rdata;
	logic              done_q;
	result_t           result_q;

	// block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= BLK_RESET;
		end else if (cfg_we) begin
			blk_q <= cfg_data;
		end
	end

	// effective modulus: zero counts as one, capped at the store depth
	always_comb begin
		n_eff = blk_q;
		if (blk_q == '0) begin
			n_eff = BLK_W'(1);
		end
		if (32'(n_eff) > WORDS) begin
			n_eff = BLK_W'(WORDS);
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ctr_q <= '0;
		end else if (cmd.clear) begin
			clr_ctr_q <= clr_ctr_q + AW'(1);
		end
	end

	// mask from the five bit positions
	always_comb begin
		mask_d = '0;
		mask_d[item.hash_low[POS_SHIFT_A +: POS_W]] = 1'b1;
		mask_d[item.hash_low[POS_SHIFT_B +: POS_W]] = 1'b1;
		mask_d[item.hash_low[POS_SHIFT_C +: POS_W]] = 1'b1;
		mask_d[item.hash_low[POS_SHIFT_D +: POS_W]] = 1'b1;
		mask_d[item.hash_low[POS_SHIFT_E +: POS_W]] = 1'b1;
	end

	// restoring remainder, DIV_BITS quotient bits per div_step
	always_comb begin
		rem_d = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_d = {rem_d[REM_W-2:0], quot_q[HIGH_W-1-i]};
			if (rem_d >= {1'b0, n_eff}) begin
				rem_d = rem_d - {1'b0, n_eff};
			end
		end
	end

	// step counter of the remainder unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CW'(1);
		end
	end

	// item payload and remainder registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.kind;
			mask_q <= mask_d;
			quot_q <= item.hash_high;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quot_q <= quot_q << DIV_BITS;
			rem_q  <= rem_d;
		end
	end

	assign status.clear_last = (clr_ctr_q == AW'(WORDS - 1));
	assign status.div_last   = (div_cnt_q == DIV_CW'(DIV_STEPS - 1));

	// word store
	assign blk_addr = AW'(rem_q);
	assign present  = ((ram_rdata & mask_q) == mask_q);
	assign do_write = cmd.check && kind_q && !present;

	always_comb begin
		ram_we    = cmd.clear || do_write;
		ram_waddr = cmd.clear ? clr_ctr_q : blk_addr;
		ram_wdata = cmd.clear ? '0 : (ram_rdata | mask_q);
	end

	bbf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (blk_addr),
		.rdata (ram_rdata)
	);

	// saturating insert counter
	always_comb begin
		count_d = count_q;
		if (do_write && (count_q != COUNT_MAX)) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.check;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			result_q.was_present  <= present;
			result_q.insert_total <= count_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/block_bloom_filter.sv =====
// ----------------------------------------------------------------------------
// block_bloom_filter
// Blocked bloom filter with one 64-bit word per key: test and insert.
// ----------------------------------------------------------------------------
//  channel   ports                  handshake
//  item      start, busy, item      taken when start high and busy low
//  result    done, result           one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data       written when cfg_we high
//
// From acceptance to its result beat an item passes the remainder unit (4 hash
// bits per cycle over the 64-bit high half), the word read, check and
// write-back, and the result register. busy drops in the cycle the result
// beat shows, so the next item may start. After reset the store is cleared
// one word a cycle with busy high. The receiver cannot stall; results are
// never held.
// ----------------------------------------------------------------------------
module block_bloom_filter #(
	parameter int WORDS = bbf_pkg::WORDS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  bbf_pkg::item_t            item,
	input  logic                      cfg_we,
	input  logic [bbf_pkg::BLK_W-1:0] cfg_data,
	output logic                      done,
	output bbf_pkg::result_t          result
);

	import bbf_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	bbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	bbf_dp #(
		.WORDS (WORDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== dv/block_bloom_filter_tb.sv =====
// ----------------------------------------------------------------------------
// block_bloom_filter_tb
// Self-checking bench for the blocked bloom filter. Item beats are driven
// through the start/busy handshake, a shadow copy of the filter words, the
// insert counter and the block count predicts each result beat, and a
// checker compares every beat against the oldest prediction. Directed lookups
// cover empty and full keys, repeated inserts and the odd block counts; the
// random traffic mixes fresh keys with replayed ones under several block
// counts and sender gap rates.
// ----------------------------------------------------------------------------
module block_bloom_filter_tb;
	import bbf_pkg::*;

	// item kinds
	localparam logic KIND_TEST   = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	// cycles with no beat in either direction before giving up
	localparam int WATCHDOG_LIMIT = 20000;
	// settle time after the last result
	localparam int DRAIN_CYCLES   = 25;
	localparam int KEY_POOL_MAX   = 64;

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             start    = 1'b0;
	logic             busy;
	item_t            item     = '0;
	logic             cfg_we   = 1'b0;
	logic [BLK_W-1:0] cfg_data = '0;
	logic             done;
	result_t          result;

	// shadow filter state
	logic [WORD_W-1:0] shadow_words [WORDS_DEFAULT] = '{default: '0};
	logic [CNT_W-1:0]  shadow_inserts = '0;
	logic [BLK_W-1:0]  shadow_blocks  = BLK_RESET;

	result_t expected_results [$];
	item_t   key_pool [$];
	result_t oldest_result;
	int      send_idle_pct = 0;
	int      errors        = 0;
	int      stall_cycles  = 0;

	block_bloom_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// lookup / insert against the shadow filter, returns the expected result
	function automatic result_t predict_lookup(input item_t it);
		result_t           res;
		logic [WORD_W-1:0] mask;
		int unsigned       blocks;
		int unsigned       word_idx;
		blocks = shadow_blocks;
		if (blocks == 0) blocks = 1;
		if (blocks > WORDS_DEFAULT) blocks = WORDS_DEFAULT;
		word_idx = int'(it.hash_high % 64'(blocks));
		mask = '0;
		mask[it.hash_low[POS_SHIFT_A +: POS_W]] = 1'b1;
		mask[it.hash_low[POS_SHIFT_B +: POS_W]] = 1'b1;
		mask[it.hash_low[POS_SHIFT_C +: POS_W]] = 1'b1;
		mask[it.hash_low[POS_SHIFT_D +: POS_W]] = 1'b1;
		mask[it.hash_low[POS_SHIFT_E +: POS_W]] = 1'b1;
		res.was_present = ((shadow_words[word_idx] & mask) == mask);
		if (it.kind == KIND_INSERT && !res.was_present) begin
			shadow_words[word_idx] |= mask;
			if (shadow_inserts != COUNT_MAX) shadow_inserts++;
		end
		res.insert_total = shadow_inserts;
		return res;
	endfunction

	function automatic item_t key_item(input logic kind, input logic [29:0] lo,
			input logic [63:0] hi);
		item_t it;
		it.kind      = kind;
		it.hash_low  = lo;
		it.hash_high = hi;
		return it;
	endfunction

	// drive one item beat; each cycle the sender idles with the set percentage
	task automatic send_item(input item_t it);
		item <= it;
		forever begin
			start <= !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct);
			@(posedge clk);
			if (start && !busy) break;
		end
		expected_results.push_back(predict_lookup(it));
	endtask

	// block count write, only once the filter has drained
	task automatic set_block_count(input logic [BLK_W-1:0] value);
		start <= 1'b0;
		while (expected_results.size() != 0 || busy !== 1'b0) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_blocks = value;
	endtask

	// empty filter, repeated inserts and extreme hash values at reset count
	task automatic test_basic_lookups();
		send_item(key_item(KIND_TEST,   30'h0, 64'h0));
		send_item(key_item(KIND_INSERT, 30'h0, 64'h0));
		send_item(key_item(KIND_TEST,   30'h0, 64'h0));
		send_item(key_item(KIND_INSERT, 30'h0, 64'h0));
		send_item(key_item(KIND_INSERT, 30'h3FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		send_item(key_item(KIND_TEST,   30'h3FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		send_item(key_item(KIND_INSERT, {6'd63, 6'd32, 6'd17, 6'd1, 6'd0}, 64'd4096));
		send_item(key_item(KIND_TEST,   {6'd0, 6'd0, 6'd0, 6'd0, 6'd63}, 64'd0));
		send_item(key_item(KIND_TEST,   {6'd63, 6'd32, 6'd17, 6'd1, 6'd0}, 64'd8192));
	endtask

	// zero block count folds every key onto word 0
	task automatic test_block_count_zero();
		set_block_count('0);
		send_item(key_item(KIND_INSERT, {6'd5, 6'd6, 6'd7, 6'd8, 6'd9}, 64'h1234_5678_9ABC_DEF0));
		send_item(key_item(KIND_TEST,   {6'd5, 6'd6, 6'd7, 6'd8, 6'd9}, 64'h0000_0000_0000_0777));
		send_item(key_item(KIND_INSERT, {6'd5, 6'd6, 6'd7, 6'd8, 6'd9}, 64'hFFFF_FFFF_FFFF_FFFF));
		send_item(key_item(KIND_TEST,   {6'd10, 6'd6, 6'd7, 6'd8, 6'd9}, 64'h5));
	endtask

	// block counts above the store size saturate, one block is word 0 only
	task automatic test_block_count_limits();
		set_block_count(13'h1FFF);
		send_item(key_item(KIND_INSERT, 30'h2AAA_AAAA, 64'd4095 + 64'd4096 * 64'd3));
		send_item(key_item(KIND_TEST,   30'h2AAA_AAAA, 64'd4095));
		set_block_count(13'd4097);
		send_item(key_item(KIND_TEST,   30'h2AAA_AAAA, 64'd8191));
		send_item(key_item(KIND_TEST,   30'h2AAA_AAAA, 64'd4096));
		set_block_count(13'd1);
		send_item(key_item(KIND_TEST,   30'h1555_5555, 64'hDEAD_BEEF_0000_0001));
		send_item(key_item(KIND_INSERT, 30'h1555_5555, 64'h8000_0000_0000_0000));
		send_item(key_item(KIND_TEST,   30'h1555_5555, 64'h7));
	endtask

	// mixed fresh and replayed keys under one block count
	task automatic test_random_traffic(input logic [BLK_W-1:0] blocks, input int n_items);
		item_t it;
		int    pick;
		set_block_count(blocks);
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < 45 && key_pool.size() != 0) begin
				it = key_pool[$urandom_range(key_pool.size() - 1)];
			end else begin
				it.hash_low  = 30'($urandom);
				it.hash_high = {$urandom, $urandom};
				// single-bit masks
				if (pick >= 90) it.hash_low = {5{6'($urandom)}};
				// low high halves hit the remainder edges
				if ($urandom_range(3) == 0) it.hash_high = 64'($urandom_range(9000));
				key_pool.push_back(it);
				if (key_pool.size() > KEY_POOL_MAX) void'(key_pool.pop_front());
			end
			it.kind = $urandom_range(1) ? KIND_INSERT : KIND_TEST;
			send_item(it);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got present=%0b total=%0d",
					$time, result.was_present, result.insert_total);
				errors++;
			end else begin
				oldest_result = expected_results.pop_front();
				if (result.was_present !== oldest_result.was_present) begin
					$display("%0t: was_present mismatch, expected %0b, got %0b",
						$time, oldest_result.was_present, result.was_present);
					errors++;
				end
				if (result.insert_total !== oldest_result.insert_total) begin
					$display("%0t: insert_total mismatch, expected %0d, got %0d",
						$time, oldest_result.insert_total, result.insert_total);
					errors++;
				end
			end
		end
	end

	// watchdog on beats in either direction
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, expected_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// sequence of tests
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// store clear pass after reset
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);

		test_basic_lookups();
		test_block_count_zero();
		test_block_count_limits();

		send_idle_pct = 23;
		test_random_traffic(13'd1, 133);
		test_random_traffic(13'd3, 133);
		test_random_traffic(13'd4096, 133);
		test_random_traffic(13'd1000, 133);

		send_idle_pct = 71;
		test_random_traffic(13'd0, 133);
		test_random_traffic(13'h1FFF, 133);
		test_random_traffic(13'd64, 133);
		test_random_traffic(13'($urandom_range(4096, 2)), 133);

		send_idle_pct = 0;
		test_random_traffic(13'd4097, 133);
		test_random_traffic(13'd2, 133);
		test_random_traffic(13'd4095, 133);
		test_random_traffic(13'($urandom_range(8191)), 133);

		// drain
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/bbf_pkg.sv
rtl/core/bbf_ram.sv
rtl/core/bbf_ctrl.sv
rtl/core/bbf_dp.sv
rtl/core/block_bloom_filter.sv
dv/block_bloom_filter_tb.sv
